>>> design/ffv_pkg.sv
package ffv_pkg;

   localparam int POS_WIDTH_DEF = 24;

   // Magnitudes entering the root are kept below 2**31.
   localparam int RED_W   = 31;
   localparam int SHIFT_W = 2;
   localparam int SQ_W    = 64;
   localparam int ROOT_W  = 32;
   localparam int SPD_W   = 16;
   localparam int DIST_W  = 24;
   localparam int VEL_W   = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [VEL_W-1:0] VEL_POS_MAX = 16'h7FFF;
   localparam logic [VEL_W-1:0] VEL_NEG_MAX = 16'h8000;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_SPEED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_RADIUS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_OFFSET    = 3'd5;

   localparam logic [SPD_W-1:0]  RST_LEADER_SPEED   = 16'd2048;
   localparam logic [SPD_W-1:0]  RST_MAX_SPEED      = 16'd6144;
   localparam logic [DIST_W-1:0] RST_NEAR_RADIUS    = 24'd1229;
   localparam logic [DIST_W-1:0] RST_CAPTURE_RADIUS = 24'd24576;
   localparam logic [DIST_W-1:0] RST_BACK_OFFSET    = 24'd4096;
   localparam logic [DIST_W-1:0] RST_SIDE_OFFSET    = 24'd7094;

   typedef struct packed {
      logic [SPD_W-1:0]  leader_speed;
      logic [SPD_W-1:0]  max_speed;
      logic [DIST_W-1:0] near_radius;
      logic [DIST_W-1:0] capture_radius;
      logic [DIST_W-1:0] back_offset;
      logic [DIST_W-1:0] side_offset;
   } cfg_type;

   // Classified vector from the follower to its slot.
   typedef struct packed {
      logic [RED_W-1:0]   ax;
      logic [RED_W-1:0]   ay;
      logic               xneg;
      logic               yneg;
      logic [SHIFT_W-1:0] shift;
   } vec_type;

endpackage

>>> design/ffv_front.sv
module ffv_front #(
   parameter int POS_WIDTH = ffv_pkg::POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ffv_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_WIDTH-1:0] leader_x,
   input  logic signed [POS_WIDTH-1:0] leader_y,
   input  logic signed [POS_WIDTH-1:0] follower_x,
   input  logic signed [POS_WIDTH-1:0] follower_y,
   input  logic                        side,
   input  logic                        q_full,
   output logic                        push,
   output ffv_pkg::vec_type            push_data
);

   localparam int OFS_W = ffv_pkg::DIST_W + 1;
   localparam int DW = ((POS_WIDTH > OFS_W) ? POS_WIDTH : OFS_W) + 2;
   localparam int SMAX = (DW > ffv_pkg::RED_W + 1) ? DW - ffv_pkg::RED_W - 1 : 0;

   logic f_en;
   logic f1_vld_ff, f2_vld_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DW-1:0] bo_e, so_e;
   logic [DW-1:0] ax_w, ay_w;
   ffv_pkg::vec_type vec_in, vec_ff;

   assign f_en = !f2_vld_ff || !q_full;
   assign req_stall = !f_en;
   assign push = f2_vld_ff && !q_full;
   assign push_data = vec_ff;

   assign bo_e = DW'($signed({1'b0, cfg.back_offset}));
   assign so_e = DW'($signed({1'b0, cfg.side_offset}));
   assign dx_in = DW'(leader_x) - bo_e - DW'(follower_x);
   assign dy_in = side ? (DW'(leader_y) - so_e - DW'(follower_y))
                       : (DW'(leader_y) + so_e - DW'(follower_y));

   assign ax_w = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign ay_w = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);

   // Both magnitudes are halved together until each fits the root unit.
   always_comb begin
      vec_in.shift = '0;
      for (int k = SMAX; k >= 0; k--) begin
         if (((ax_w >> k) >> ffv_pkg::RED_W) == '0 && ((ay_w >> k) >> ffv_pkg::RED_W) == '0) begin
            vec_in.shift = ffv_pkg::SHIFT_W'(k);
         end
      end
      vec_in.ax = ffv_pkg::RED_W'(ax_w >> vec_in.shift);
      vec_in.ay = ffv_pkg::RED_W'(ay_w >> vec_in.shift);
      vec_in.xneg = dx_ff[DW-1];
      vec_in.yneg = dy_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (f_en) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         vec_ff <= vec_in;
      end
   end

endmodule

>>> design/ffv_queue.sv
module ffv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ffv_pkg::vec_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ffv_pkg::vec_type pop_data
);

   localparam int PTR_W = $clog2(ffv_pkg::QUEUE_DEPTH);

   ffv_pkg::vec_type mem_ff [ffv_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0] count_ff, count_in;

   assign full = (count_ff == (PTR_W+1)'(ffv_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/ffv_div.sv
module ffv_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 24,
   parameter int Q_W   = 16,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [SB_W-1:0]  sb_in,
   output logic             out_vld,
   output logic [Q_W-1:0]   quo,
   output logic [SB_W-1:0]  sb_out
);

   // One quotient bit per stage; the quotient is known to fit in Q_W bits.
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   lo_ff  [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [SB_W-1:0]  sb_ff  [Q_W];
   logic             vld_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_p, den_p;
      logic [Q_W-1:0]   lo_p, quo_p;
      logic [SB_W-1:0]  sb_p;
      logic             vld_p;
      logic [DEN_W:0]   r2;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_p = DEN_W'(num >> Q_W);
         assign den_p = den;
         assign lo_p  = num[Q_W-1:0];
         assign quo_p = '0;
         assign sb_p  = sb_in;
         assign vld_p = in_vld;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign den_p = den_ff[k-1];
         assign lo_p  = lo_ff[k-1];
         assign quo_p = quo_ff[k-1];
         assign sb_p  = sb_ff[k-1];
         assign vld_p = vld_ff[k-1];
      end

      assign r2 = {rem_p, lo_p[Q_W-1]};
      assign ge = (r2 >= {1'b0, den_p});
      assign rem_in = ge ? DEN_W'(r2 - {1'b0, den_p}) : r2[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_p;
            lo_ff[k]  <= lo_p << 1;
            quo_ff[k] <= {quo_p[Q_W-2:0], ge};
            sb_ff[k]  <= sb_p;
         end
      end
   end

   assign out_vld = vld_ff[Q_W-1];
   assign quo = quo_ff[Q_W-1];
   assign sb_out = sb_ff[Q_W-1];

endmodule

>>> design/ffv_back.sv
module ffv_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ffv_pkg::cfg_type                cfg,
   input  logic                            q_not_empty,
   input  ffv_pkg::vec_type                q_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [ffv_pkg::VEL_W-1:0] vel_x,
   output logic signed [ffv_pkg::VEL_W-1:0] vel_y,
   output logic [ffv_pkg::DIST_W-1:0]      slot_distance
);

   localparam int RED_W  = ffv_pkg::RED_W;
   localparam int ROOT_W = ffv_pkg::ROOT_W;
   localparam int SQ_W   = ffv_pkg::SQ_W;
   localparam int SPD_W  = ffv_pkg::SPD_W;
   localparam int DIST_W = ffv_pkg::DIST_W;
   localparam int VEL_W  = ffv_pkg::VEL_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int N1_W   = DIST_W + SPD_W;
   localparam int P2_W   = SPD_W + RED_W;
   localparam int N2_W   = P2_W + 1;
   localparam int Q2_W   = SPD_W + 1;

   typedef struct packed {
      ffv_pkg::vec_type  vec;
      logic [ROOT_W-1:0] dr;
      logic [DIST_W-1:0] slot_dist;
      logic              cap;
      logic              copy;
      logic              bneg;
   } sb1_type;

   typedef struct packed {
      logic              xneg;
      logic              yneg;
      logic [DIST_W-1:0] slot_dist;
      logic              copy;
   } sb2_type;

   logic en;
   assign en = !rsp_valid || !rsp_stall;
   assign pop = q_not_empty && en;

   // Squares and their sum.
   logic s0_vld_ff, s1_vld_ff;
   logic [2*RED_W-1:0] s0_sqx_ff, s0_sqy_ff;
   logic [SQ_W-1:0] s1_sum_ff;
   ffv_pkg::vec_type s0_vec_ff, s1_vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= q_not_empty;
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_sqx_ff <= (2*RED_W)'(q_data.ax) * (2*RED_W)'(q_data.ax);
         s0_sqy_ff <= (2*RED_W)'(q_data.ay) * (2*RED_W)'(q_data.ay);
         s0_vec_ff <= q_data;
         s1_sum_ff <= SQ_W'(s0_sqx_ff) + SQ_W'(s0_sqy_ff);
         s1_vec_ff <= s0_vec_ff;
      end
   end

   // Integer square root, one result bit per stage.
   logic [REM_W-1:0]  rt_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] rt_root_ff [ROOT_W];
   logic [SQ_W-1:0]   rt_x_ff    [ROOT_W];
   ffv_pkg::vec_type  rt_vec_ff  [ROOT_W];
   logic              rt_vld_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SQ_W-1:0]   x_p;
      ffv_pkg::vec_type  vec_p;
      logic              vld_p;
      logic [REM_W+1:0]  r2, trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign x_p    = s1_sum_ff;
         assign vec_p  = s1_vec_ff;
         assign vld_p  = s1_vld_ff;
      end else begin : g_next
         assign rem_p  = rt_rem_ff[k-1];
         assign root_p = rt_root_ff[k-1];
         assign x_p    = rt_x_ff[k-1];
         assign vec_p  = rt_vec_ff[k-1];
         assign vld_p  = rt_vld_ff[k-1];
      end

      assign r2 = {rem_p, x_p[SQ_W-1:SQ_W-2]};
      assign trial = {2'b00, root_p, 2'b01};
      assign ge = (r2 >= trial);
      assign rem_in = ge ? REM_W'(r2 - trial) : r2[REM_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[k] <= 1'b0;
         end else if (en) begin
            rt_vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_rem_ff[k]  <= rem_in;
            rt_root_ff[k] <= {root_p[ROOT_W-2:0], ge};
            rt_x_ff[k]    <= x_p << 2;
            rt_vec_ff[k]  <= vec_p;
         end
      end
   end

   // Distance and speed band.
   logic [ROOT_W-1:0] dr;
   logic [ROOT_W+1:0] dwide;
   logic [DIST_W-1:0] dist_in;
   logic              cap_in, mid_in;
   logic [SPD_W:0]    bdiff;
   sb1_type           c_sb_ff;
   logic              c_vld_ff, d_vld_ff;
   logic [DIST_W-1:0] c_a_ff;
   logic [SPD_W-1:0]  c_bmag_ff;
   logic [N1_W-1:0]   d_num_ff;
   sb1_type           d_sb_ff;

   assign dr = rt_root_ff[ROOT_W-1];
   assign dwide = (ROOT_W+2)'(dr) << rt_vec_ff[ROOT_W-1].shift;
   assign dist_in = (dwide > (ROOT_W+2)'(ffv_pkg::DIST_MAX)) ? ffv_pkg::DIST_MAX
                                                           : dwide[DIST_W-1:0];
   assign cap_in = (dr != '0) && (dist_in >= cfg.capture_radius);
   assign mid_in = (dr != '0) && !cap_in && (dist_in >= cfg.near_radius);
   assign bdiff = {1'b0, cfg.max_speed} - {1'b0, cfg.leader_speed};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= rt_vld_ff[ROOT_W-1];
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_sb_ff.vec       <= rt_vec_ff[ROOT_W-1];
         c_sb_ff.dr        <= dr;
         c_sb_ff.slot_dist <= dist_in;
         c_sb_ff.cap       <= cap_in;
         c_sb_ff.copy      <= !cap_in && !mid_in;
         c_sb_ff.bneg      <= bdiff[SPD_W];
         c_a_ff            <= dist_in - cfg.near_radius;
         c_bmag_ff         <= bdiff[SPD_W] ? SPD_W'(-bdiff) : bdiff[SPD_W-1:0];
         d_num_ff          <= N1_W'(c_a_ff) * N1_W'(c_bmag_ff);
         d_sb_ff           <= c_sb_ff;
      end
   end

   // Interpolation quotient over the band between the two radii.
   logic             div1_vld;
   logic [SPD_W-1:0] div1_q;
   logic [$bits(sb1_type)-1:0] div1_sb;
   sb1_type          e_sb;

   ffv_div #(
      .NUM_W(N1_W),
      .DEN_W(DIST_W),
      .Q_W  (SPD_W),
      .SB_W ($bits(sb1_type))
   ) u_div_speed (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .in_vld (d_vld_ff),
      .num    (d_num_ff),
      .den    (cfg.capture_radius - cfg.near_radius),
      .sb_in  (d_sb_ff),
      .out_vld(div1_vld),
      .quo    (div1_q),
      .sb_out (div1_sb)
   );

   assign e_sb = div1_sb;

   logic              e_vld_ff, f_vld_ff, g_vld_ff;
   logic [SPD_W-1:0]  e_v_ff;
   sb1_type           e_sb_ff, f_sb_ff, g_sb_ff;
   logic [P2_W-1:0]   f_px_ff, f_py_ff;
   logic [N2_W-1:0]   g_nx_ff, g_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= div1_vld;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (e_sb.cap) begin
            e_v_ff <= cfg.max_speed;
         end else if (e_sb.bneg) begin
            e_v_ff <= cfg.leader_speed - div1_q;
         end else begin
            e_v_ff <= cfg.leader_speed + div1_q;
         end
         e_sb_ff <= e_sb;
         f_px_ff <= P2_W'(e_v_ff) * P2_W'(e_sb_ff.vec.ax);
         f_py_ff <= P2_W'(e_v_ff) * P2_W'(e_sb_ff.vec.ay);
         f_sb_ff <= e_sb_ff;
         // Adding half the divisor rounds the quotient to nearest.
         g_nx_ff <= N2_W'(f_px_ff) + N2_W'(f_sb_ff.dr >> 1);
         g_ny_ff <= N2_W'(f_py_ff) + N2_W'(f_sb_ff.dr >> 1);
         g_sb_ff <= f_sb_ff;
      end
   end

   // Bearing components scaled by speed over distance.
   sb2_type          g_sb2;
   logic             div2_vld;
   logic [Q2_W-1:0]  qx, qy;
   logic [$bits(sb2_type)-1:0] div2_sb;
   sb2_type          h_sb;
   logic             ay_nz;

   assign g_sb2.xneg = g_sb_ff.vec.xneg;
   assign g_sb2.yneg = g_sb_ff.vec.yneg;
   assign g_sb2.slot_dist = g_sb_ff.slot_dist;
   assign g_sb2.copy = g_sb_ff.copy;

   ffv_div #(
      .NUM_W(N2_W),
      .DEN_W(ROOT_W),
      .Q_W  (Q2_W),
      .SB_W ($bits(sb2_type))
   ) u_div_x (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .in_vld (g_vld_ff),
      .num    (g_nx_ff),
      .den    (g_sb_ff.dr),
      .sb_in  (g_sb2),
      .out_vld(div2_vld),
      .quo    (qx),
      .sb_out (div2_sb)
   );

   logic div3_vld;

   ffv_div #(
      .NUM_W(N2_W),
      .DEN_W(ROOT_W),
      .Q_W  (Q2_W),
      .SB_W (1)
   ) u_div_y (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .in_vld (g_vld_ff),
      .num    (g_ny_ff),
      .den    (g_sb_ff.dr),
      .sb_in  (g_sb_ff.vec.ay != '0),
      .out_vld(div3_vld),
      .quo    (qy),
      .sb_out (ay_nz)
   );

   assign h_sb = div2_sb;

   function automatic logic [VEL_W-1:0] sat_vel(input logic [Q2_W-1:0] q, input logic neg);
      logic [VEL_W-1:0] r;
      if (neg) begin
         r = (q >= Q2_W'(32768)) ? ffv_pkg::VEL_NEG_MAX : VEL_W'(-q[VEL_W-1:0]);
      end else begin
         r = (q >= Q2_W'(32767)) ? ffv_pkg::VEL_POS_MAX : q[VEL_W-1:0];
      end
      return r;
   endfunction

   logic              rsp_valid_ff;
   logic [VEL_W-1:0]  vel_x_ff, vel_y_ff;
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div2_vld && div3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= h_sb.slot_dist;
         if (h_sb.copy) begin
            vel_x_ff <= '0;
            vel_y_ff <= (cfg.leader_speed > ffv_pkg::VEL_POS_MAX) ? ffv_pkg::VEL_POS_MAX
                                                                 : cfg.leader_speed;
         end else begin
            vel_x_ff <= sat_vel(qy, !h_sb.yneg && ay_nz);
            vel_y_ff <= sat_vel(qx, h_sb.xneg);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign vel_x = $signed(vel_x_ff);
   assign vel_y = $signed(vel_y_ff);
   assign slot_distance = dist_ff;

endmodule

>>> design/formation_follower_velocity.sv
// Leader-follower formation velocity command.
// Input channel (req_*): one transaction carries leader and follower positions
// (signed fixed point, POS_WIDTH bits) and the side flag that picks the slot.
// Result channel (rsp_*): one transaction per input with the commanded follower
// velocity (signed Q4.12) and the distance to the slot (unsigned Q12.12).
// Configuration (csr_*): registers are written by index; the user must write
// them only while the block is idle, which the block does not enforce. Writes
// take effect at the next clock edge and cannot be read back. Input runs to
// rsp_valid through 2 front stages, the queue, 32 square root stages, a 16
// stage speed divider and a 17 stage scaling divider, plus registers around the
// multipliers. One transaction is accepted per cycle while req_stall is low.
// When the receiver stalls, the back pipeline holds; the front keeps accepting
// until the 4-entry queue fills, then req_stall rises.
// A synchronous reset empties the pipeline and queue and restores the default
// speeds, radii and offsets.
module formation_follower_velocity #(
   parameter int POS_WIDTH = ffv_pkg::POS_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ffv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ffv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [POS_WIDTH-1:0]         req_leader_x,
   input  logic signed [POS_WIDTH-1:0]         req_leader_y,
   input  logic signed [POS_WIDTH-1:0]         req_follower_x,
   input  logic signed [POS_WIDTH-1:0]         req_follower_y,
   input  logic                                req_side,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ffv_pkg::VEL_W-1:0]    rsp_vel_x,
   output logic signed [ffv_pkg::VEL_W-1:0]    rsp_vel_y,
   output logic [ffv_pkg::DIST_W-1:0]          rsp_slot_distance
);

   ffv_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_speed   <= ffv_pkg::RST_LEADER_SPEED;
         cfg_ff.max_speed      <= ffv_pkg::RST_MAX_SPEED;
         cfg_ff.near_radius    <= ffv_pkg::RST_NEAR_RADIUS;
         cfg_ff.capture_radius <= ffv_pkg::RST_CAPTURE_RADIUS;
         cfg_ff.back_offset    <= ffv_pkg::RST_BACK_OFFSET;
         cfg_ff.side_offset    <= ffv_pkg::RST_SIDE_OFFSET;
      end else if (csr_we) begin
         unique case (csr_index)
            ffv_pkg::CSR_LEADER_SPEED:   cfg_ff.leader_speed   <= csr_wdata[ffv_pkg::SPD_W-1:0];
            ffv_pkg::CSR_MAX_SPEED:      cfg_ff.max_speed      <= csr_wdata[ffv_pkg::SPD_W-1:0];
            ffv_pkg::CSR_NEAR_RADIUS:    cfg_ff.near_radius    <= csr_wdata;
            ffv_pkg::CSR_CAPTURE_RADIUS: cfg_ff.capture_radius <= csr_wdata;
            ffv_pkg::CSR_BACK_OFFSET:    cfg_ff.back_offset    <= csr_wdata;
            ffv_pkg::CSR_SIDE_OFFSET:    cfg_ff.side_offset    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic             q_full, q_push, q_pop, q_not_empty;
   ffv_pkg::vec_type q_push_data, q_pop_data;

   ffv_front #(
      .POS_WIDTH(POS_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .leader_x  (req_leader_x),
      .leader_y  (req_leader_y),
      .follower_x(req_follower_x),
      .follower_y(req_follower_y),
      .side      (req_side),
      .q_full    (q_full),
      .push      (q_push),
      .push_data (q_push_data)
   );

   ffv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_data (q_pop_data)
   );

   ffv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_not_empty  (q_not_empty),
      .q_data       (q_pop_data),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .vel_x        (rsp_vel_x),
      .vel_y        (rsp_vel_y),
      .slot_distance(rsp_slot_distance)
   );

endmodule
